### hdl/trtc_pkg.sv
// Shared types, constants and elaboration-time ROM helpers for the type R
// thermocouple EMF-to-temperature core. No dependencies.
package trtc_pkg;

  // Number of Horner steps after the leading coefficient; shorter segments are
  // padded with leading zero coefficients up to degree ten.
  localparam int NUM_STEPS = 10;
  localparam int MAX_DEG   = 10;

  // EMF limits in microvolts.
  localparam logic signed [15:0] EMF_MIN   = -16'sd226;
  localparam logic signed [15:0] EMF_MAX   = 16'sd21103;
  localparam logic signed [15:0] SEG1_LOW  = 16'sd1923;
  localparam logic signed [15:0] SEG2_LOW  = 16'sd11361;
  localparam logic signed [15:0] SEG3_LOW  = 16'sd19739;

  // Reciprocal of 125 scaled by 2^24, rounded up.
  localparam logic [17:0] RECIP_125  = 18'd134218;
  localparam int          RECIP_SHIFT = 24;

  localparam logic [62:0] SAT_MAG = {63{1'b1}};
  localparam logic signed [18:0] TEMP_MAX = 19'sd262143;
  localparam logic signed [18:0] TEMP_MIN = -19'sd262144;

  // Pipeline payload that travels beside the accumulator.
  typedef struct packed {
    logic        oor;
    logic [1:0]  seg;
    logic        xneg;
    logic [62:0] xmag;
  } pipe_ctl_t;

  // Decimal coefficient table: value = mant / 10^dec.
  localparam logic signed [63:0] COEF_MANT [32] = '{
    64'sd0, 64'sd18891380, -64'sd93835290, 64'sd13068619, -64'sd22703580,
    64'sd35145659, -64'sd38953900, 64'sd28239471, -64'sd12607281,
    64'sd31353611, -64'sd33187769,
    64'sd1334584505, 64'sd1472644573, -64'sd1844024844, 64'sd4031129726,
    -64'sd6249428360, 64'sd6468412049, -64'sd4458750426,
    64'sd1994710149, -64'sd5313401790, 64'sd6481976217,
    -64'sd8199599416, 64'sd1553962042, -64'sd8342197663,
    64'sd4279433549, -64'sd1191577910, 64'sd1492290091,
    64'sd3406177836, -64'sd7023729171, 64'sd5582903813,
    -64'sd1952394635, 64'sd2560740231
  };
  localparam int COEF_DEC [32] = '{
    0, 5, 6, 5, 5, 5, 5, 5, 5, 6, 7,
    8, 7, 8, 9, 10, 11, 12, 13, 15, 17,
    8, 7, 9, 10, 11, 13,
    5, 6, 7, 8, 10
  };
  localparam int SEG_BASE [4] = '{0, 11, 21, 27};
  localparam int SEG_LEN  [4] = '{11, 10, 6, 5};

  // Fixed-point coefficient of power pos in segment seg, rounded to nearest
  // with ties away from zero and saturated to 63-bit magnitude. Evaluated at
  // elaboration only.
  function automatic logic signed [63:0] coef_fixed(input int seg, input int pos,
                                                    input int frac);
    logic [127:0]       num;
    logic [127:0]       q;
    logic [127:0]       rem;
    logic [127:0]       den;
    logic [63:0]        mag;
    logic signed [63:0] mant;
    logic signed [63:0] res;
    int                 idx;
    int                 i;
    res = '0;
    if (pos < SEG_LEN[seg]) begin
      idx  = SEG_BASE[seg] + pos;
      mant = COEF_MANT[idx];
      den  = 128'd1;
      for (i = 0; i < COEF_DEC[idx]; i++) begin
        den = den * 128'd10;
      end
      mag = (mant < 0) ? 64'(-mant) : 64'(mant);
      num = {64'd0, mag} << frac;
      q   = '0;
      rem = '0;
      for (i = 127; i >= 0; i--) begin
        rem = {rem[126:0], num[i]};
        if (rem >= den) begin
          rem  = rem - den;
          q[i] = 1'b1;
        end
      end
      if ((rem << 1) >= den) begin
        q = q + 128'd1;
      end
      if (q > {65'd0, SAT_MAG}) begin
        q = {65'd0, SAT_MAG};
      end
      res = (mant < 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
    end
    return res;
  endfunction

  // round(b * 2^(frac-3) / 125), the fractional share of the mV conversion.
  function automatic logic [62:0] frac_tab(input int b, input int frac);
    logic [63:0] v;
    logic [63:0] q;
    logic [63:0] r;
    v = 64'(b) << (frac - 3);
    q = v / 125;
    r = v % 125;
    if ((r << 1) >= 64'd125) begin
      q = q + 64'd1;
    end
    return q[62:0];
  endfunction

endpackage

### hdl/trtc_frontend.sv
// Input stage: range check, segment select, leading-coefficient load and
// EMF-to-millivolt conversion in fixed point, remainder share rounded. Depends on trtc_pkg.
module trtc_frontend #(
  parameter int COEFF_FRAC_BITS = 40
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [15:0]      emf,
  output logic                    out_valid,
  output trtc_pkg::pipe_ctl_t     out_ctl,
  output logic signed [63:0]      out_acc
);

  localparam int TAB_SHIFT = COEFF_FRAC_BITS - 3;

  // Stage 1 registers.
  logic        v1_r;
  logic        oor1_r;
  logic [1:0]  seg1_r;
  logic        neg1_r;
  logic [14:0] mag1_r;
  // Stage 2 registers.
  logic        v2_r;
  logic        oor2_r;
  logic [1:0]  seg2_r;
  logic        neg2_r;
  logic [14:0] mag2_r;
  logic [7:0]  quo2_r;
  // Stage 3 registers.
  logic                v3_r;
  trtc_pkg::pipe_ctl_t ctl3_r;
  logic signed [63:0]  acc3_r;

  logic        oor_c;
  logic [1:0]  seg_c;
  logic [15:0] abs_c;
  logic [32:0] recip_prod;
  logic [14:0] quo125;
  logic [6:0]  rem125;
  logic [62:0] tab_w [128];
  logic [62:0] x_c;
  logic signed [63:0] coef_c [4];

  // Fractional table, one constant per remainder value.
  genvar gi;
  for (gi = 0; gi < 128; gi++) begin : g_tab
    if (gi < 125) begin : g_used
      assign tab_w[gi] = trtc_pkg::frac_tab(gi, COEFF_FRAC_BITS);
    end else begin : g_unused
      assign tab_w[gi] = '0;
    end
  end

  // Leading coefficient of each segment.
  for (gi = 0; gi < 4; gi++) begin : g_lead
    assign coef_c[gi] = trtc_pkg::coef_fixed(gi, trtc_pkg::MAX_DEG, COEFF_FRAC_BITS);
  end

  // Range check and segment select.
  always_comb begin
    oor_c = (emf < trtc_pkg::EMF_MIN) || (emf > trtc_pkg::EMF_MAX);
    abs_c = emf[15] ? 16'(-emf) : 16'(emf);
    if (emf < trtc_pkg::SEG1_LOW) begin
      seg_c = 2'd0;
    end else if (emf < trtc_pkg::SEG2_LOW) begin
      seg_c = 2'd1;
    end else if (emf < trtc_pkg::SEG3_LOW) begin
      seg_c = 2'd2;
    end else begin
      seg_c = 2'd3;
    end
  end

  // Quotient by 125 through a scaled reciprocal.
  assign recip_prod = 33'(mag1_r) * 33'(trtc_pkg::RECIP_125);
  assign quo125     = 15'(recip_prod >> trtc_pkg::RECIP_SHIFT);

  // Millivolt value: whole part by shift, remainder through the table.
  always_comb begin
    rem125 = 7'(mag2_r - 15'(quo2_r * 15'd125));
    x_c    = (63'(quo2_r) << TAB_SHIFT) + tab_w[rem125];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    oor1_r      <= oor_c;
    seg1_r      <= seg_c;
    neg1_r      <= emf[15];
    mag1_r      <= abs_c[14:0];
    oor2_r      <= oor1_r;
    seg2_r      <= seg1_r;
    neg2_r      <= neg1_r;
    mag2_r      <= mag1_r;
    quo2_r      <= quo125[7:0];
    ctl3_r.oor  <= oor2_r;
    ctl3_r.seg  <= seg2_r;
    ctl3_r.xneg <= neg2_r;
    ctl3_r.xmag <= x_c;
    acc3_r      <= coef_c[seg2_r];
  end

  assign out_valid = v3_r;
  assign out_ctl   = ctl3_r;
  assign out_acc   = acc3_r;

endmodule

### hdl/trtc_horner_step.sv
// One Horner step, acc * x rounded at the binary point plus one coefficient,
// split over three register stages. Depends on trtc_pkg.
module trtc_horner_step #(
  parameter int COEFF_FRAC_BITS = 40,
  parameter int POS = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  trtc_pkg::pipe_ctl_t in_ctl,
  input  logic signed [63:0]  in_acc,
  output logic                out_valid,
  output trtc_pkg::pipe_ctl_t out_ctl,
  output logic signed [63:0]  out_acc
);

  localparam logic [127:0] HALF = 128'd1 << (COEFF_FRAC_BITS - 1);
  localparam logic signed [64:0] SUM_MAX = {2'b00, trtc_pkg::SAT_MAG};
  localparam logic signed [64:0] SUM_MIN = -SUM_MAX;

  logic                va_r, vb_r, vc_r;
  trtc_pkg::pipe_ctl_t ctla_r, ctlb_r, ctlc_r;
  logic                nega_r, negb_r;
  logic [63:0]         p00_r;
  logic [62:0]         p01_r, p10_r;
  logic [61:0]         p11_r;
  logic [62:0]         magb_r;
  logic signed [63:0]  accc_r;

  logic [63:0]         amag;
  logic [63:0]         p00_nxt;
  logic [62:0]         p01_nxt, p10_nxt;
  logic [61:0]         p11_nxt;
  logic [127:0]        full;
  logic [62:0]         mag_nxt;
  logic signed [64:0]  prod;
  logic signed [64:0]  sum;
  logic signed [63:0]  acc_nxt;
  logic signed [63:0]  coef_c [4];

  genvar gi;
  for (gi = 0; gi < 4; gi++) begin : g_coef
    assign coef_c[gi] = trtc_pkg::coef_fixed(gi, POS, COEFF_FRAC_BITS);
  end

  // Partial products of the magnitudes.
  always_comb begin
    amag    = in_acc[63] ? 64'(-in_acc) : 64'(in_acc);
    p00_nxt = 64'(amag[31:0]) * 64'(in_ctl.xmag[31:0]);
    p01_nxt = 63'(amag[31:0]) * 63'(in_ctl.xmag[62:32]);
    p10_nxt = 63'(amag[62:32]) * 63'(in_ctl.xmag[31:0]);
    p11_nxt = 62'(amag[62:32]) * 62'(in_ctl.xmag[62:32]);
  end

  // Sum the partial products, round at the binary point and saturate.
  always_comb begin
    full = {64'd0, p00_r} + ({65'd0, p01_r} << 32) + ({65'd0, p10_r} << 32)
         + ({66'd0, p11_r} << 64) + HALF;
    if ((full >> (COEFF_FRAC_BITS + 63)) != 128'd0) begin
      mag_nxt = trtc_pkg::SAT_MAG;
    end else begin
      mag_nxt = full[COEFF_FRAC_BITS +: 63];
    end
  end

  // Add the coefficient with saturation.
  always_comb begin
    prod = negb_r ? -$signed({2'b00, magb_r}) : $signed({2'b00, magb_r});
    sum  = prod + 65'(coef_c[ctlb_r.seg]);
    if (sum > SUM_MAX) begin
      acc_nxt = 64'(SUM_MAX);
    end else if (sum < SUM_MIN) begin
      acc_nxt = 64'(SUM_MIN);
    end else begin
      acc_nxt = sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    ctla_r <= in_ctl;
    nega_r <= in_acc[63] ^ in_ctl.xneg;
    p00_r  <= p00_nxt;
    p01_r  <= p01_nxt;
    p10_r  <= p10_nxt;
    p11_r  <= p11_nxt;
    ctlb_r <= ctla_r;
    negb_r <= nega_r;
    magb_r <= mag_nxt;
    ctlc_r <= ctlb_r;
    accc_r <= acc_nxt;
  end

  assign out_valid = vc_r;
  assign out_ctl   = ctlc_r;
  assign out_acc   = accc_r;

endmodule

### hdl/trtc_outscale.sv
// Output stage: scale the accumulator to hundredths of a degree, round,
// clamp to 19 bits and zero out-of-range results. Depends on trtc_pkg.
module trtc_outscale #(
  parameter int COEFF_FRAC_BITS = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  trtc_pkg::pipe_ctl_t in_ctl,
  input  logic signed [63:0]  in_acc,
  output logic                out_strobe,
  output logic signed [18:0]  out_temp,
  output logic                out_oor
);

  localparam logic [70:0] HALF = 71'd1 << (COEFF_FRAC_BITS - 1);
  localparam logic [70:0] POS_LIM = 71'd262143;
  localparam logic [70:0] NEG_LIM = 71'd262144;

  logic               v1_r, v2_r;
  logic               oor1_r, oor2_r;
  logic               neg1_r;
  logic [69:0]        prod1_r;
  logic signed [18:0] temp2_r;

  logic [63:0]        amag;
  logic [70:0]        q;
  logic signed [18:0] temp_nxt;

  assign amag = in_acc[63] ? 64'(-in_acc) : 64'(in_acc);

  // Round, then clamp to the signed 19-bit range.
  always_comb begin
    q = ({1'b0, prod1_r} + HALF) >> COEFF_FRAC_BITS;
    if (oor1_r) begin
      temp_nxt = '0;
    end else if (neg1_r) begin
      temp_nxt = (q > NEG_LIM) ? trtc_pkg::TEMP_MIN : 19'(-$signed({1'b0, q[18:0]}));
    end else begin
      temp_nxt = (q > POS_LIM) ? trtc_pkg::TEMP_MAX : $signed(q[18:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    oor1_r  <= in_ctl.oor;
    neg1_r  <= in_acc[63];
    prod1_r <= 70'(amag[62:0]) * 70'd100;
    oor2_r  <= oor1_r;
    temp2_r <= temp_nxt;
  end

  assign out_strobe = v2_r;
  assign out_temp   = temp2_r;
  assign out_oor    = oor2_r;

endmodule

### hdl/type_r_thermocouple_emf_to_temp_core.sv
// Type R thermocouple EMF-to-temperature core, top level.
// Depends on trtc_pkg, trtc_frontend, trtc_horner_step and trtc_outscale.
//
// A transaction is taken at every clock edge with start high; busy is
// always low, so one sample enters per cycle. Each sample produces exactly
// one result, shown for one cycle with out_strobe high, after input
// conversion, ten Horner steps (partial products, rounding, coefficient
// add) and output scaling. Results leave in the order of the samples and
// cannot be held off.
module type_r_thermocouple_emf_to_temp_core #(
  parameter int COEFF_FRAC_BITS = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_emf_microvolts,
  output logic               out_strobe,
  output logic signed [18:0] out_temp_centi_c,
  output logic               out_out_of_range
);

  localparam int N = trtc_pkg::NUM_STEPS;

  logic                valid_w [N+1];
  trtc_pkg::pipe_ctl_t ctl_w   [N+1];
  logic signed [63:0]  acc_w   [N+1];

  // The pipeline never stalls.
  assign busy = 1'b0;

  trtc_frontend #(
    .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
  ) u_frontend (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .emf      (in_emf_microvolts),
    .out_valid(valid_w[0]),
    .out_ctl  (ctl_w[0]),
    .out_acc  (acc_w[0])
  );

  // Horner chain, highest remaining power first.
  genvar gi;
  for (gi = 0; gi < N; gi++) begin : g_step
    trtc_horner_step #(
      .COEFF_FRAC_BITS(COEFF_FRAC_BITS),
      .POS            (N - 1 - gi)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (valid_w[gi]),
      .in_ctl   (ctl_w[gi]),
      .in_acc   (acc_w[gi]),
      .out_valid(valid_w[gi+1]),
      .out_ctl  (ctl_w[gi+1]),
      .out_acc  (acc_w[gi+1])
    );
  end

  trtc_outscale #(
    .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
  ) u_outscale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (valid_w[N]),
    .in_ctl    (ctl_w[N]),
    .in_acc    (acc_w[N]),
    .out_strobe(out_strobe),
    .out_temp  (out_temp_centi_c),
    .out_oor   (out_out_of_range)
  );

endmodule
